// File: hw/rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants for greedy box NMS
// Store geometry, box layout, pipeline latency and controller types.
// ----------------------------------------------------------------------------
package gbn_pkg;

   // kept-box store
   localparam int MAX_KEPT = 64;
   localparam int KEEP_AW  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
   localparam int CNT_W    = $clog2(MAX_KEPT + 1);

   // field widths
   localparam int COORD_W = 16;
   localparam int SCORE_W = 16;
   localparam int CLASS_W = 8;
   localparam int THR_W   = 16;
   localparam int BOX_W   = 4 * COORD_W;

   // threshold after reset: 0.5 in Q0.16
   localparam logic [THR_W-1:0] IOU_THR_RESET = 16'h8000;

   // path from a store read to its overlap flag: RAM read plus four stages
   localparam int PIPE_LAT = 5;
   localparam int DRAIN_W  = $clog2(PIPE_LAT);
   localparam logic [DRAIN_W-1:0] DRAIN_LOAD = DRAIN_W'(PIPE_LAT - 1);

   typedef struct packed {
      logic signed [COORD_W-1:0] left;
      logic signed [COORD_W-1:0] top;
      logic [COORD_W-1:0]        width;
      logic [COORD_W-1:0]        height;
   } box_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               rd_en;
      logic [KEEP_AW-1:0] rd_addr;
      logic               wr_en;
      logic [KEEP_AW-1:0] wr_addr;
   } ram_cmd_type;

   typedef struct packed {
      logic valid;
      logic hit;
   } hit_type;

   typedef struct packed {
      logic done;
      logic kept;
      logic full;
   } verdict_type;

endpackage

// File: hw/rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// gbn_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module gbn_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/gbn_iou.sv
// ----------------------------------------------------------------------------
// gbn_iou: pipelined overlap test
// Compares the current box with one kept box per cycle and flags
// intersection * 65536 > threshold * union. Four register stages.
// ----------------------------------------------------------------------------
module gbn_iou import gbn_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  box_type          cur_box,
   input  box_type          kept_box,
   input  logic [THR_W-1:0] threshold,
   output hit_type          hit
);
   // stage 1: overlap spans
   logic signed [COORD_W+1:0] cur_x_end, cur_y_end, kep_x_end, kep_y_end;
   logic signed [COORD_W+1:0] x_hi, y_hi;
   logic signed [COORD_W-1:0] x_lo, y_lo;
   logic signed [COORD_W+2:0] w_raw, h_raw;
   logic                      no_overlap;
   logic [COORD_W-1:0]        w_in, h_in;
   logic [COORD_W-1:0]        w_ff, h_ff, kw_ff, kh_ff;
   logic                      v1_ff;

   // stage 2: areas
   logic [2*COORD_W-1:0] inter_in, area_k_in, area_c_in;
   logic [2*COORD_W-1:0] inter2_ff, area_k_ff, area_c_ff;
   logic                 v2_ff;

   // stage 3: union
   logic [2*COORD_W:0]   uni_in;
   logic [2*COORD_W:0]   uni_ff;
   logic [2*COORD_W-1:0] inter3_ff;
   logic                 v3_ff;

   // stage 4: threshold product
   logic [THR_W+2*COORD_W:0] prod_in;
   logic [THR_W+2*COORD_W:0] prod_ff;
   logic [2*COORD_W-1:0]     inter4_ff;
   logic                     uni_zero_ff;
   logic                     v4_ff;

   logic [THR_W+2*COORD_W:0] lhs;

   // span ends and overlap widths, clamp a negative span to no intersection
   always_comb begin
      cur_x_end = {{2{cur_box.left[COORD_W-1]}}, cur_box.left} + {2'b00, cur_box.width};
      cur_y_end = {{2{cur_box.top[COORD_W-1]}}, cur_box.top} + {2'b00, cur_box.height};
      kep_x_end = {{2{kept_box.left[COORD_W-1]}}, kept_box.left} + {2'b00, kept_box.width};
      kep_y_end = {{2{kept_box.top[COORD_W-1]}}, kept_box.top} + {2'b00, kept_box.height};
      x_hi = (cur_x_end < kep_x_end) ? cur_x_end : kep_x_end;
      y_hi = (cur_y_end < kep_y_end) ? cur_y_end : kep_y_end;
      x_lo = (cur_box.left > kept_box.left) ? cur_box.left : kept_box.left;
      y_lo = (cur_box.top > kept_box.top) ? cur_box.top : kept_box.top;
      w_raw = {x_hi[COORD_W+1], x_hi} - {{3{x_lo[COORD_W-1]}}, x_lo};
      h_raw = {y_hi[COORD_W+1], y_hi} - {{3{y_lo[COORD_W-1]}}, y_lo};
      no_overlap = w_raw[COORD_W+2] | h_raw[COORD_W+2];
      w_in = no_overlap ? '0 : w_raw[COORD_W-1:0];
      h_in = no_overlap ? '0 : h_raw[COORD_W-1:0];
   end

   // areas of intersection, kept box and current box
   always_comb begin
      inter_in  = w_ff * h_ff;
      area_k_in = kw_ff * kh_ff;
      area_c_in = cur_box.width * cur_box.height;
   end

   assign uni_in  = {1'b0, area_c_ff} + {1'b0, area_k_ff} - {1'b0, inter2_ff};
   assign prod_in = threshold * uni_ff;
   assign lhs     = {1'b0, inter4_ff, {THR_W{1'b0}}};

   // advance valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // advance datapath
   always_ff @(posedge clock) begin
      w_ff        <= w_in;
      h_ff        <= h_in;
      kw_ff       <= kept_box.width;
      kh_ff       <= kept_box.height;
      inter2_ff   <= inter_in;
      area_k_ff   <= area_k_in;
      area_c_ff   <= area_c_in;
      uni_ff      <= uni_in;
      inter3_ff   <= inter2_ff;
      prod_ff     <= prod_in;
      inter4_ff   <= inter3_ff;
      uni_zero_ff <= (uni_ff == '0);
   end

   // empty union never overlaps
   assign hit.valid = v4_ff;
   assign hit.hit   = v4_ff & ~uni_zero_ff & (lhs > prod_ff);

endmodule

// File: hw/rtl/gbn_ctrl.sv
// ----------------------------------------------------------------------------
// gbn_ctrl: scan sequencer for greedy box NMS
// Walks the kept store, gathers overlap flags, decides keep or suppress
// and appends survivors; clears the store count at the end of a frame.
// ----------------------------------------------------------------------------
module gbn_ctrl import gbn_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        item_last,
   input  hit_type     hit,
   output logic        busy,
   output ram_cmd_type ram_cmd,
   output verdict_type verdict
);
   state_type          state_ff, state_in;
   logic [KEEP_AW-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [DRAIN_W-1:0] drain_ff, drain_in;
   logic               hit_ff, hit_in;
   logic               keep, full;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         count_ff <= '0;
         drain_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         drain_ff <= drain_in;
         hit_ff   <= hit_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign keep = ~hit_ff;
   assign full = keep & (count_ff == CNT_W'(MAX_KEPT));

   // next state and store commands
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      count_in = count_ff;
      drain_in = drain_ff;
      hit_in   = hit_ff | (hit.valid & hit.hit);
      ram_cmd  = '0;
      verdict  = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               hit_in   = 1'b0;
               idx_in   = '0;
               state_in = (count_ff == '0) ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN: begin
            // one store read per cycle
            ram_cmd.rd_en   = 1'b1;
            ram_cmd.rd_addr = idx_ff;
            idx_in          = idx_ff + 1'b1;
            if (CNT_W'(idx_ff) == count_ff - CNT_W'(1)) begin
               state_in = ST_DRAIN;
               drain_in = DRAIN_LOAD;
            end
         end
         ST_DRAIN: begin
            // wait for the last flag to leave the overlap pipeline
            if (drain_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               drain_in = drain_ff - 1'b1;
            end
         end
         ST_DONE: begin
            verdict.done    = 1'b1;
            verdict.kept    = keep & ~full;
            verdict.full    = full;
            ram_cmd.wr_en   = keep & ~full;
            ram_cmd.wr_addr = count_ff[KEEP_AW-1:0];
            if (item_last) begin
               count_in = '0;
            end else if (keep & ~full) begin
               count_in = count_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEPT))
      else $error("kept count beyond store depth");

   a_read_valid: assert property (@(posedge clock) disable iff (reset)
      ram_cmd.rd_en |-> (CNT_W'(ram_cmd.rd_addr) < count_ff))
      else $error("read of an entry above the kept count");

   a_hit_window: assert property (@(posedge clock) disable iff (reset)
      hit.valid |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("overlap flag outside the scan window");

   a_empty_store: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && count_ff == '0) |=> (state_ff == ST_DONE))
      else $error("empty store did not skip the scan");

   a_append: assert property (@(posedge clock) disable iff (reset)
      (ram_cmd.wr_en && !item_last) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not advance the kept count");
`endif

endmodule

// File: hw/rtl/greedy_box_nms.sv
// ----------------------------------------------------------------------------
// greedy_box_nms: class-agnostic greedy non-maximum suppression
// Tests each incoming box against every kept box of the frame and reports
// whether it survives; survivors are appended to the kept store.
//
//   channel   ports            handshake
//   request   start, req_*     taken when start is high and busy is low
//   result    rsp_*            rsp_valid high for one cycle, cannot stall
//   config    csr_*            written when csr_write is high
//
// Each item reads every kept box of the frame, one store read per cycle
// through the single RAM read port, then drains the overlap pipeline and
// decides. With an empty store the scan and drain are skipped. A new item
// is accepted only after the decision, once busy falls. The result is
// registered from the decision. Reset empties the store; its contents need
// no clearing pass. The receiver cannot stall, so results are never held.
// ----------------------------------------------------------------------------
module greedy_box_nms import gbn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   // request
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_box_left,
   input  logic signed [COORD_W-1:0] req_box_top,
   input  logic [COORD_W-1:0]        req_box_width,
   input  logic [COORD_W-1:0]        req_box_height,
   input  logic [SCORE_W-1:0]        req_box_score,
   input  logic [CLASS_W-1:0]        req_class_id,
   input  logic                      req_frame_last,
   // result
   output logic                      rsp_valid,
   output logic                      rsp_kept,
   output logic signed [COORD_W-1:0] rsp_out_left,
   output logic signed [COORD_W-1:0] rsp_out_top,
   output logic [COORD_W-1:0]        rsp_out_width,
   output logic [COORD_W-1:0]        rsp_out_height,
   output logic [SCORE_W-1:0]        rsp_out_score,
   output logic [CLASS_W-1:0]        rsp_out_class,
   output logic                      rsp_out_last,
   output logic                      rsp_store_full,
   // configuration
   input  logic                      csr_write,
   input  logic [THR_W-1:0]          csr_wdata
);
   logic [THR_W-1:0]   thr_ff;
   box_type            cur_ff;
   logic [SCORE_W-1:0] score_ff;
   logic [CLASS_W-1:0] class_ff;
   logic               last_ff;
   logic               accept;

   ram_cmd_type        ram_cmd;
   verdict_type        verdict;
   hit_type            hit;
   logic [BOX_W-1:0]   rd_data;
   box_type            kept_box;
   logic               rd_valid_ff;

   logic               rsp_valid_ff;
   logic               rsp_kept_ff, rsp_full_ff, rsp_last_ff;
   box_type            rsp_box_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic [CLASS_W-1:0] rsp_class_ff;

   assign accept = start & ~busy;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= IOU_THR_RESET;
      end else if (csr_write) begin
         thr_ff <= csr_wdata;
      end
   end

   // hold the accepted transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff.left   <= req_box_left;
         cur_ff.top    <= req_box_top;
         cur_ff.width  <= req_box_width;
         cur_ff.height <= req_box_height;
         score_ff      <= req_box_score;
         class_ff      <= req_class_id;
         last_ff       <= req_frame_last;
      end
   end

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item_last (last_ff),
      .hit       (hit),
      .busy      (busy),
      .ram_cmd   (ram_cmd),
      .verdict   (verdict)
   );

   gbn_ram #(
      .WIDTH (BOX_W),
      .DEPTH (MAX_KEPT)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_cmd.wr_en),
      .wr_addr (ram_cmd.wr_addr),
      .wr_data (cur_ff),
      .rd_en   (ram_cmd.rd_en),
      .rd_addr (ram_cmd.rd_addr),
      .rd_data (rd_data)
   );

   // read data is valid in the cycle after the read
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= ram_cmd.rd_en;
      end
   end

   assign kept_box = rd_data;

   gbn_iou u_iou (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .cur_box   (cur_ff),
      .kept_box  (kept_box),
      .threshold (thr_ff),
      .hit       (hit)
   );

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= verdict.done;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (verdict.done) begin
         rsp_kept_ff  <= verdict.kept;
         rsp_full_ff  <= verdict.full;
         rsp_last_ff  <= last_ff;
         rsp_box_ff   <= cur_ff;
         rsp_score_ff <= score_ff;
         rsp_class_ff <= class_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_out_left   = rsp_box_ff.left;
   assign rsp_out_top    = rsp_box_ff.top;
   assign rsp_out_width  = rsp_box_ff.width;
   assign rsp_out_height = rsp_box_ff.height;
   assign rsp_out_score  = rsp_score_ff;
   assign rsp_out_class  = rsp_class_ff;
   assign rsp_out_last   = rsp_last_ff;
   assign rsp_store_full = rsp_full_ff;

endmodule
